// ===== sv/tempo_synced_feedback_delay_defines.svh =====
// ----------------------------------------------------------------------------
// tempo synced feedback delay: assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef TEMPO_SYNCED_FEEDBACK_DELAY_DEFINES_SVH
`define TEMPO_SYNCED_FEEDBACK_DELAY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSFD_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tsfd check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSFD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tsfd check failed");

`endif

// ===== sv/tsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfd_pkg
// types and fixed constants of the tempo synced feedback delay
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsfd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int CLOCKS_W   = 6;
  localparam int SPC_W      = 16;
  localparam int POS_W      = 5;
  localparam int LP_FRAC    = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_CLOCKS = 2'd0,
    REG_MIX_GAIN     = 2'd1,
    REG_FEEDBACK     = 2'd2,
    REG_HIGHCUT      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_LOWPASS,
    ST_HIGHCUT,
    ST_FEEDBACK,
    ST_MIX
  } tsfd_state_t;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // tick positions that start a measurement (multiples of twelve)
  localparam logic [POS_W-1:0] POS_BEAT      = 5'd0;
  localparam logic [POS_W-1:0] POS_HALF_BEAT = 5'd12;
  localparam logic [POS_W-1:0] POS_NEXT_BEAT = 5'd24;

  localparam logic [GAIN_W-1:0]   LP_TAKE     = 16'd6554;
  localparam int                  TEMPO_TOL   = 100;
  localparam int                  WRITE_START = 8192;
  localparam logic [SPC_W-1:0]    SPC_MAX     = 16'hFFFF;

  // x / 3 = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x below 2^19
  localparam logic [18:0] DIV3_RECIP = 19'd349526;
  localparam int          DIV3_SHIFT = 20;

  localparam logic [CLOCKS_W-1:0] RST_DELAY_CLOCKS = 6'd12;
  localparam logic [GAIN_W-1:0]   RST_MIX_GAIN     = 16'd32768;
  localparam logic [GAIN_W-1:0]   RST_FEEDBACK     = 16'd32768;
  localparam logic [GAIN_W-1:0]   RST_HIGHCUT      = 16'd0;

endpackage

// ===== sv/tsfd_ifs.sv =====
// ----------------------------------------------------------------------------
// tsfd stream interfaces
// valid/ready channels for request items and output samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsfd_in_if #(parameter int SAMPLE_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic signed [SAMPLE_BITS-1:0]  in_sample;
  logic [tsfd_pkg::POS_W-1:0]     clock_pos;

  modport source (output valid, req_type, in_sample, clock_pos, input ready);
  modport sink   (input valid, req_type, in_sample, clock_pos, output ready);
endinterface

interface tsfd_out_if #(parameter int SAMPLE_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_BITS-1:0]  out_left;
  logic signed [SAMPLE_BITS-1:0]  out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

// ===== sv/tsfd_mac.sv =====
// ----------------------------------------------------------------------------
// tsfd_mac
// shared blend unit: base * 2^16 + diff * gain, rounded half up by 2^16 or 2^24
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsfd_mac #(
  parameter int W = 24
) (
  input  logic signed [W-1:0]                 base,
  input  logic signed [W:0]                   diff,
  input  logic [tsfd_pkg::GAIN_W-1:0]         gain,
  input  logic                                round24,
  output logic signed [W+2:0]                 res
);

  localparam int SW = W + 19;
  localparam logic [SW-1:0] HALF16 = SW'(1) << 15;
  localparam logic [SW-1:0] HALF24 = SW'(1) << 23;

  logic signed [W+17:0] prod;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] rnd;

  assign prod = diff * $signed({1'b0, gain});
  assign sum  = (SW'(base) <<< 16) + SW'(prod);
  assign rnd  = sum + $signed(round24 ? HALF24 : HALF16);

  always_comb begin
    if (round24) begin
      res = $signed({{8{rnd[SW-1]}}, rnd[SW-1:24]});
    end else begin
      res = $signed(rnd[SW-1:16]);
    end
  end

endmodule

// ===== sv/tempo_synced_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// tempo_synced_feedback_delay
// mono tempo synced echo over a circular sample memory with feedback,
// a highcut lowpass on the echo path and a dry/wet output mix
// ----------------------------------------------------------------------------
//   channel  direction  handshake     payload
//   in_ch    sink       valid/ready   req_type, in_sample, clock_pos
//   out_ch   source     valid/ready   out_left, out_right
//   cfg      write      cfg_we        cfg_index, cfg_wdata
//
// a sample passes in order through memory read, lowpass, highcut, feedback write, mix;
// each step after the read is one pass through the shared blend multiplier
// a clock tick passes through the tick state and gives no output
// reset needs no memory sweep: a fill count marks written entries, others read 0
// the output register holds a result while the next item is accepted; the mix
// step waits only if the previous result has not yet been taken
`timescale 1ns / 1ps

module tempo_synced_feedback_delay #(
  parameter int ADDR_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tsfd_in_if.sink                             in_ch,
  tsfd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [tsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = ADDR_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int LW = SB + tsfd_pkg::LP_FRAC;
  localparam int OW = LW + 3;
  localparam int DEPTH = 1 << AW;
  localparam int START_I = tsfd_pkg::WRITE_START % DEPTH;
  localparam logic [AW-1:0] WR_START = AW'(START_I);
  localparam logic [AW:0]   FILL_FULL = {1'b1, {AW{1'b0}}};
  localparam int PW = AW + 17;
  localparam logic signed [21:0] TOL_P = 22'(tsfd_pkg::TEMPO_TOL);
  localparam logic signed [21:0] TOL_N = -TOL_P;

  tsfd_pkg::tsfd_state_t state_r, state_nxt;

  // configuration
  logic [tsfd_pkg::CLOCKS_W-1:0] delay_clocks_r;
  logic [tsfd_pkg::GAIN_W-1:0]   mix_gain_r, feedback_gain_r, highcut_gain_r;

  // block state
  logic [AW-1:0]               write_idx_r, last_tick_r;
  logic [AW:0]                 fill_r;
  logic [tsfd_pkg::SPC_W-1:0]  spc_r;
  logic signed [LW-1:0]        lp_r;

  // item in flight
  logic                        req_tick_r;
  logic [tsfd_pkg::POS_W-1:0]  pos_r;
  logic signed [SB-1:0]        x_r;
  logic signed [SB-1:0]        rd_data_r;
  logic                        rd_valid_r;
  logic signed [SB-1:0]        wet_r, w_r;

  // output register
  logic                        out_valid_r;
  logic signed [SB-1:0]        out_data_r;

  logic signed [SB-1:0] dly_mem [DEPTH];

  // control decode
  logic in_ready, in_xfer, slot_free, mem_we, out_load;

  assign in_xfer   = in_ch.valid && in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsfd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_ch.req_type == tsfd_pkg::REQ_TICK) ? tsfd_pkg::ST_TICK
                                                             : tsfd_pkg::ST_LOWPASS;
        end
      end
      tsfd_pkg::ST_TICK:     state_nxt = tsfd_pkg::ST_IDLE;
      tsfd_pkg::ST_LOWPASS:  state_nxt = tsfd_pkg::ST_HIGHCUT;
      tsfd_pkg::ST_HIGHCUT:  state_nxt = tsfd_pkg::ST_FEEDBACK;
      tsfd_pkg::ST_FEEDBACK: state_nxt = tsfd_pkg::ST_MIX;
      tsfd_pkg::ST_MIX: begin
        if (slot_free) begin
          state_nxt = tsfd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      tsfd_pkg::ST_IDLE:     in_ready = 1'b1;
      tsfd_pkg::ST_FEEDBACK: mem_we   = 1'b1;
      tsfd_pkg::ST_MIX:      out_load = slot_free;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsfd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_clocks_r  <= tsfd_pkg::RST_DELAY_CLOCKS;
      mix_gain_r      <= tsfd_pkg::RST_MIX_GAIN;
      feedback_gain_r <= tsfd_pkg::RST_FEEDBACK;
      highcut_gain_r  <= tsfd_pkg::RST_HIGHCUT;
    end else if (cfg_we) begin
      case (tsfd_pkg::cfg_idx_t'(cfg_index))
        tsfd_pkg::REG_DELAY_CLOCKS: delay_clocks_r  <= cfg_wdata[tsfd_pkg::CLOCKS_W-1:0];
        tsfd_pkg::REG_MIX_GAIN:     mix_gain_r      <= cfg_wdata;
        tsfd_pkg::REG_FEEDBACK:     feedback_gain_r <= cfg_wdata;
        tsfd_pkg::REG_HIGHCUT:      highcut_gain_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // read address: write position minus tracked tick spacing times delay length
  logic [21:0]   back_prod;
  logic [AW-1:0] rd_addr, rd_off;
  logic          rd_ok;

  assign back_prod = spc_r * delay_clocks_r;
  assign rd_addr   = write_idx_r - back_prod[AW-1:0];
  assign rd_off    = rd_addr - WR_START;
  // entries are written in order from the start position, so the fill count
  // tells which ones hold data
  assign rd_ok     = {1'b0, rd_off} < fill_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data_r <= dly_mem[rd_addr];
    end
  end

  // the feedback step result goes straight into the memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dly_mem[write_idx_r] <= smp_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_tick_r <= in_ch.req_type;
      pos_r      <= in_ch.clock_pos;
      x_r        <= in_ch.in_sample;
      rd_valid_r <= rd_ok;
    end
  end

  // shared blend unit operands
  logic signed [SB-1:0] d_cur;
  logic signed [LW-1:0] d_frac, x_ext, wet_ext, w_ext;
  logic signed [LW-1:0] mac_base;
  logic signed [LW:0]   mac_diff;
  logic [tsfd_pkg::GAIN_W-1:0] mac_gain;
  logic                 mac_r24;
  logic signed [OW-1:0] mac_res;

  assign d_cur   = rd_valid_r ? rd_data_r : '0;
  assign d_frac  = $signed({d_cur, {tsfd_pkg::LP_FRAC{1'b0}}});
  assign x_ext   = $signed({{tsfd_pkg::LP_FRAC{x_r[SB-1]}}, x_r});
  assign wet_ext = $signed({{tsfd_pkg::LP_FRAC{wet_r[SB-1]}}, wet_r});
  assign w_ext   = $signed({{tsfd_pkg::LP_FRAC{w_r[SB-1]}}, w_r});

  always_comb begin
    case (state_r)
      tsfd_pkg::ST_LOWPASS: begin
        mac_base = lp_r;
        mac_diff = $signed({d_frac[LW-1], d_frac}) - $signed({lp_r[LW-1], lp_r});
        mac_gain = tsfd_pkg::LP_TAKE;
        mac_r24  = 1'b0;
      end
      tsfd_pkg::ST_HIGHCUT: begin
        mac_base = d_frac;
        mac_diff = $signed({lp_r[LW-1], lp_r}) - $signed({d_frac[LW-1], d_frac});
        mac_gain = highcut_gain_r;
        mac_r24  = 1'b1;
      end
      tsfd_pkg::ST_FEEDBACK: begin
        mac_base = x_ext;
        mac_diff = $signed({wet_ext[LW-1], wet_ext}) - $signed({x_ext[LW-1], x_ext});
        mac_gain = feedback_gain_r;
        mac_r24  = 1'b0;
      end
      default: begin
        mac_base = x_ext;
        mac_diff = $signed({w_ext[LW-1], w_ext}) - $signed({x_ext[LW-1], x_ext});
        mac_gain = mix_gain_r;
        mac_r24  = 1'b0;
      end
    endcase
  end

  tsfd_mac #(.W(LW)) u_tsfd_mac (
    .base    (mac_base),
    .diff    (mac_diff),
    .gain    (mac_gain),
    .round24 (mac_r24),
    .res     (mac_res)
  );

  // saturation to lowpass width and to sample width
  logic                 lp_fits, smp_fits;
  logic signed [LW-1:0] lp_sat;
  logic signed [SB-1:0] smp_sat;

  assign lp_fits  = (mac_res[OW-1:LW-1] == '0) || (mac_res[OW-1:LW-1] == '1);
  assign smp_fits = (mac_res[OW-1:SB-1] == '0) || (mac_res[OW-1:SB-1] == '1);

  always_comb begin
    if (lp_fits) begin
      lp_sat = mac_res[LW-1:0];
    end else if (mac_res[OW-1]) begin
      lp_sat = $signed({1'b1, {(LW-1){1'b0}}});
    end else begin
      lp_sat = $signed({1'b0, {(LW-1){1'b1}}});
    end
    if (smp_fits) begin
      smp_sat = mac_res[SB-1:0];
    end else if (mac_res[OW-1]) begin
      smp_sat = $signed({1'b1, {(SB-1){1'b0}}});
    end else begin
      smp_sat = $signed({1'b0, {(SB-1){1'b1}}});
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tsfd_pkg::ST_HIGHCUT:  wet_r <= smp_sat;
      tsfd_pkg::ST_FEEDBACK: w_r   <= smp_sat;
      default: ;
    endcase
  end

  // tempo measurement
  logic [AW-1:0]          gap;
  logic [19:0]            spc12;
  logic signed [21:0]     tdiff;
  logic                   measure, retune;
  logic [PW-1:0]          q_prod;
  logic [19:0]            q_ext;
  logic [tsfd_pkg::SPC_W-1:0] spc_new;

  assign gap     = write_idx_r - last_tick_r;
  assign spc12   = 20'({spc_r, 3'b000}) + 20'({spc_r, 2'b00});
  assign tdiff   = $signed({2'b00, spc12}) - $signed(22'(gap));
  assign measure = pos_r inside {tsfd_pkg::POS_BEAT, tsfd_pkg::POS_HALF_BEAT,
                                 tsfd_pkg::POS_NEXT_BEAT};
  assign retune  = (tdiff > TOL_P) || (tdiff < TOL_N);
  // gap / 12 as (gap / 4) / 3
  assign q_prod  = gap[AW-1:2] * tsfd_pkg::DIV3_RECIP;
  assign q_ext   = 20'(q_prod[PW-1:tsfd_pkg::DIV3_SHIFT]);
  assign spc_new = (q_ext > 20'(tsfd_pkg::SPC_MAX)) ? tsfd_pkg::SPC_MAX : q_ext[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_idx_r <= WR_START;
      last_tick_r <= '0;
      fill_r      <= '0;
      spc_r       <= '0;
      lp_r        <= '0;
    end else begin
      case (state_r)
        tsfd_pkg::ST_TICK: begin
          if (req_tick_r && measure) begin
            last_tick_r <= write_idx_r;
            if (retune) begin
              spc_r <= spc_new;
            end
          end
        end
        tsfd_pkg::ST_LOWPASS: lp_r <= lp_sat;
        tsfd_pkg::ST_FEEDBACK: begin
          write_idx_r <= write_idx_r + AW'(1);
          if (fill_r != FILL_FULL) begin
            fill_r <= fill_r + (AW+1)'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= smp_sat;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_data_r;
  assign out_ch.out_right = out_data_r;

endmodule

// ===== sv/tsfd_checker.sv =====
// ----------------------------------------------------------------------------
// tsfd_checker
// port-level checks of the tempo synced feedback delay, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tempo_synced_feedback_delay_defines.svh"

module tsfd_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_req_type,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_left,
  input logic signed [SAMPLE_BITS-1:0] out_right
);

  // a stalled result holds
  `TSFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left))

  // both channels carry the same mono sample
  `TSFD_ASSERT_SAME(a_mono, out_valid, out_left == out_right)

  // one item at a time: busy right after a transfer in
  `TSFD_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)

  // a fresh result comes from an earlier sample transfer in, not from a tick
  `TSFD_ASSERT_SAME(a_out_src, $rose(out_valid),
                    $past(in_valid && in_ready && (in_req_type == tsfd_pkg::REQ_SAMPLE), 5))

endmodule

bind tempo_synced_feedback_delay tsfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tsfd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_left    (out_ch.out_left),
  .out_right   (out_ch.out_right)
);

// ===== sim/tempo_synced_feedback_delay_checker.sv =====
// ----------------------------------------------------------------------------
// tempo_synced_feedback_delay_checker
// watches the request, output and register ports of the echo block, keeps
// its own bit-exact copy of the delay memory, tempo tracker and filters, and
// compares every output transfer against the oldest predicted mix sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tempo_synced_feedback_delay_checker #(
  parameter int ADDR_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tsfd_in_if                               in_mon,
  tsfd_out_if                              out_mon,
  input  logic                             cfg_we,
  input  logic [tsfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               n_fail,
  output int                               n_checked,
  output int                               n_outstanding
);

  localparam int     MEM_DEPTH  = 1 << ADDR_BITS;
  localparam int     FRAC_BITS  = 8;
  localparam int     TICK_STEP  = 12;
  localparam longint UNITY      = 65536;
  localparam longint LP_KEEP_Q  = 58982;
  localparam longint LP_TAKE_Q  = 6554;
  localparam longint S_MAX      = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint S_MIN      = -(longint'(1) <<< (SAMPLE_BITS - 1));
  localparam longint LP_MAX_V   = (longint'(1) <<< (SAMPLE_BITS + FRAC_BITS - 1)) - 1;
  localparam longint LP_MIN_V   = -(longint'(1) <<< (SAMPLE_BITS + FRAC_BITS - 1));

  logic signed [SAMPLE_BITS-1:0] echo_mem [0:MEM_DEPTH-1];
  logic [ADDR_BITS-1:0]          wr_ptr;
  logic [ADDR_BITS-1:0]          last_beat_ptr;
  logic [15:0]                   tempo_spc;
  longint                        lp_level;

  logic [tsfd_pkg::CLOCKS_W-1:0] dly_clocks;
  logic [tsfd_pkg::GAIN_W-1:0]   mix_gain;
  logic [tsfd_pkg::GAIN_W-1:0]   fb_gain;
  logic [tsfd_pkg::GAIN_W-1:0]   hc_gain;

  logic signed [SAMPLE_BITS-1:0] expected_mix_q [$];

  // round to nearest with halves toward plus infinity
  function automatic longint round_q(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] echo_sample(
    input logic signed [SAMPLE_BITS-1:0] dry
  );
    logic [31:0]          span;
    logic [ADDR_BITS-1:0] rd_ptr;
    longint               x, tap, tap_frac, hc, fb, mg, wet, fed, y;
    x        = longint'(dry);
    span     = tempo_spc * dly_clocks;
    rd_ptr   = wr_ptr - span[ADDR_BITS-1:0];
    tap      = longint'(echo_mem[rd_ptr]);
    tap_frac = tap <<< FRAC_BITS;
    lp_level = sat(round_q(lp_level * LP_KEEP_Q + tap_frac * LP_TAKE_Q, 16),
                   LP_MIN_V, LP_MAX_V);
    hc  = longint'(hc_gain);
    wet = sat(round_q(lp_level * hc + tap_frac * (UNITY - hc), 16 + FRAC_BITS),
              S_MIN, S_MAX);
    fb  = longint'(fb_gain);
    fed = sat(round_q(x * (UNITY - fb) + wet * fb, 16), S_MIN, S_MAX);
    // read comes first, so a zero delay sees the entry from one lap ago
    echo_mem[wr_ptr] = SAMPLE_BITS'(fed);
    wr_ptr = wr_ptr + 1'b1;
    mg = longint'(mix_gain);
    y  = sat(round_q(x * (UNITY - mg) + fed * mg, 16), S_MIN, S_MAX);
    return SAMPLE_BITS'(y);
  endfunction

  function automatic void beat_tick(input logic [tsfd_pkg::POS_W-1:0] pos);
    logic [ADDR_BITS-1:0] gap;
    longint               drift;
    int unsigned          per_clock;
    if (pos % TICK_STEP != 0) return;
    gap           = wr_ptr - last_beat_ptr;
    drift         = longint'(tempo_spc) * TICK_STEP - longint'(gap);
    last_beat_ptr = wr_ptr;
    if (drift > tsfd_pkg::TEMPO_TOL || drift < -tsfd_pkg::TEMPO_TOL) begin
      per_clock = gap / TICK_STEP;
      tempo_spc = (per_clock > 65535) ? 16'hFFFF : 16'(per_clock);
    end
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    n_fail++;
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < MEM_DEPTH; i++) echo_mem[i] = '0;
      wr_ptr        = ADDR_BITS'(tsfd_pkg::WRITE_START);
      last_beat_ptr = '0;
      tempo_spc     = '0;
      lp_level      = 0;
      dly_clocks    = tsfd_pkg::RST_DELAY_CLOCKS;
      mix_gain      = tsfd_pkg::RST_MIX_GAIN;
      fb_gain       = tsfd_pkg::RST_FEEDBACK;
      hc_gain       = tsfd_pkg::RST_HIGHCUT;
      expected_mix_q.delete();
      n_fail        = 0;
      n_checked     = 0;
      n_outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tsfd_pkg::REG_DELAY_CLOCKS:
            dly_clocks = cfg_wdata[tsfd_pkg::CLOCKS_W-1:0];
          tsfd_pkg::REG_MIX_GAIN: mix_gain = cfg_wdata[tsfd_pkg::GAIN_W-1:0];
          tsfd_pkg::REG_FEEDBACK: fb_gain  = cfg_wdata[tsfd_pkg::GAIN_W-1:0];
          tsfd_pkg::REG_HIGHCUT:  hc_gain  = cfg_wdata[tsfd_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_mix_q.size() == 0) begin
          report("output transfer with nothing expected", longint'(out_mon.out_left), 0);
        end else begin
          want = expected_mix_q.pop_front();
          n_checked++;
          if (out_mon.out_left !== want)
            report("out_left", longint'(out_mon.out_left), longint'(want));
          if (out_mon.out_right !== want)
            report("out_right", longint'(out_mon.out_right), longint'(want));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == tsfd_pkg::REQ_TICK) beat_tick(in_mon.clock_pos);
        else expected_mix_q.push_back(echo_sample(in_mon.in_sample));
      end
      n_outstanding <= expected_mix_q.size();
    end
  end

endmodule

// ===== sim/tempo_synced_feedback_delay_tb.sv =====
// ----------------------------------------------------------------------------
// tempo_synced_feedback_delay_tb
// drives samples, tempo ticks and register writes into the echo block with
// random idling on both channels, including a stretch at zero delay,
// and gives the verdict from the checker's mismatch and outstanding counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tempo_synced_feedback_delay_tb;

  localparam int ADDR_BITS        = 16;
  localparam int SAMPLE_BITS      = 16;
  localparam int HALF_PERIOD      = 4;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_ITEMS     = 750;
  localparam int ZERO_DELAY_ITEMS = 150;
  localparam int SETTLE_CYCLES    = 16;
  localparam int IDLE_LIMIT       = 2000;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [tsfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tsfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bit steady = 1'b0;
  int fail_count, checked_count, pending_count;
  int n_samples, n_ticks, n_settings;
  int quiet_cycles;

  tsfd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  tsfd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  tempo_synced_feedback_delay #(
    .ADDR_BITS   (ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tempo_synced_feedback_delay_checker #(
    .ADDR_BITS   (ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .n_fail        (fail_count),
    .n_checked     (checked_count),
    .n_outstanding (pending_count)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (steady) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 30);
  end

  // no transfer on either channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [tsfd_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd32768;
      default: return 16'($urandom);
    endcase
  endfunction

  // upper bits of the word are junk now and then, only the low six count
  function automatic logic [tsfd_pkg::CFG_DATA_W-1:0] pick_clocks();
    logic [tsfd_pkg::CLOCKS_W-1:0] dc;
    case ($urandom_range(4))
      0:       dc = 6'd0;
      1:       dc = 6'd48;
      default: dc = 6'($urandom_range(48));
    endcase
    return {($urandom_range(3) == 0) ? 10'($urandom) : 10'd0, dc};
  endfunction

  task automatic send(input logic kind, input logic signed [SAMPLE_BITS-1:0] smp,
                      input logic [tsfd_pkg::POS_W-1:0] pos);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 30) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= kind;
    in_ch.in_sample <= smp;
    in_ch.clock_pos <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kind == tsfd_pkg::REQ_TICK) n_ticks++;
    else n_samples++;
  endtask

  // hold the sender until every expected sample has come back, then let a
  // trailing tick finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [tsfd_pkg::CFG_DATA_W-1:0] dc_word,
                            input logic [tsfd_pkg::GAIN_W-1:0] mix, fb, hc);
    cfg_we    <= 1'b1;
    cfg_index <= tsfd_pkg::REG_DELAY_CLOCKS;
    cfg_wdata <= dc_word;
    @(posedge clk);
    cfg_index <= tsfd_pkg::REG_MIX_GAIN;
    cfg_wdata <= mix;
    @(posedge clk);
    cfg_index <= tsfd_pkg::REG_FEEDBACK;
    cfg_wdata <= fb;
    @(posedge clk);
    cfg_index <= tsfd_pkg::REG_HIGHCUT;
    cfg_wdata <= hc;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // a run of samples with stray ticks, closed by a tick on a beat position
  task automatic beat_pattern();
    int                         span;
    logic [tsfd_pkg::POS_W-1:0] beat_pos;
    case ($urandom_range(9))
      0:       span = 0;
      1, 2:    span = $urandom_range(300, 100);
      default: span = $urandom_range(40, 1);
    endcase
    repeat (span) begin
      if ($urandom_range(9) == 0) send(tsfd_pkg::REQ_TICK, pick_sample(), 5'($urandom));
      else send(tsfd_pkg::REQ_SAMPLE, pick_sample(), 5'($urandom));
    end
    case ($urandom_range(2))
      0:       beat_pos = tsfd_pkg::POS_BEAT;
      1:       beat_pos = tsfd_pkg::POS_HALF_BEAT;
      default: beat_pos = tsfd_pkg::POS_NEXT_BEAT;
    endcase
    send(tsfd_pkg::REQ_TICK, pick_sample(), beat_pos);
  endtask

  initial begin
    int base;
    int phase;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= tsfd_pkg::REQ_SAMPLE;
    in_ch.in_sample <= '0;
    in_ch.clock_pos <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes of the sample, then tempo ticks
    send(tsfd_pkg::REQ_SAMPLE, 16'sh7FFF, 5'd0);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh8000, 5'd31);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh0000, 5'd0);
    send(tsfd_pkg::REQ_SAMPLE, 16'shFFFF, 5'd0);
    send(tsfd_pkg::REQ_TICK, 16'sh0000, tsfd_pkg::POS_BEAT);
    send(tsfd_pkg::REQ_TICK, 16'sh7FFF, 5'd25);
    send(tsfd_pkg::REQ_TICK, 16'sh8000, 5'd31);
    send(tsfd_pkg::REQ_TICK, 16'sh0000, 5'd7);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh0001, 5'd0);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh7FFF, 5'd0);
    // short gap after a long one pulls the tempo down
    send(tsfd_pkg::REQ_TICK, 16'sh0000, tsfd_pkg::POS_NEXT_BEAT);
    drain();
    write_regs(16'd48, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh7FFF, 5'd0);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh8000, 5'd0);
    send(tsfd_pkg::REQ_TICK, 16'sh0000, tsfd_pkg::POS_HALF_BEAT);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh7FFF, 5'd0);
    drain();
    write_regs(16'd0, 16'd0, 16'd0, 16'd0);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh0001, 5'd0);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh8000, 5'd0);
    send(tsfd_pkg::REQ_SAMPLE, 16'sh7FFF, 5'd0);

    base  = n_samples + n_ticks;
    phase = 0;
    while (n_samples + n_ticks - base < RANDOM_ITEMS) begin
      drain();
      steady <= (phase == 2) || ($urandom_range(5) == 0);
      write_regs(pick_clocks(), pick_gain(), pick_gain(), pick_gain());
      repeat (3) beat_pattern();
      if ($urandom_range(2) == 0) drain();
      phase++;
    end

    // back to back at zero delay: each read lands on the entry about to be written
    drain();
    steady <= 1'b1;
    write_regs(16'd0, pick_gain(), pick_gain(), pick_gain());
    repeat (ZERO_DELAY_ITEMS) begin
      if ($urandom_range(63) == 0) send(tsfd_pkg::REQ_TICK, pick_sample(), 5'($urandom));
      else send(tsfd_pkg::REQ_SAMPLE, pick_sample(), 5'($urandom));
    end
    drain();

    $display("run covered %0d samples and %0d tempo ticks under %0d register settings,",
             n_samples, n_ticks, n_settings);
    $display("a zero-delay stretch included; %0d output samples compared",
             checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tsfd_pkg.sv
sv/tsfd_ifs.sv
sv/tsfd_mac.sv
sv/tempo_synced_feedback_delay.sv
sv/tsfd_checker.sv
sim/tempo_synced_feedback_delay_checker.sv
sim/tempo_synced_feedback_delay_tb.sv
